### rtl/kuwahara_rgb_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef KUWAHARA_RGB_FILTER_ASSERT_SVH
`define KUWAHARA_RGB_FILTER_ASSERT_SVH
// Implication checked every clock outside reset.
`define KWF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define KWF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/kwf_pkg.sv
// Package with payload types, codes and state encoding of the Kuwahara filter.
`default_nettype none
package kwf_pkg;
  // Line store size: columns per row and the largest quadrant reach
  localparam int unsigned StoreCols = 2048;
  localparam int unsigned RadiusMax = 7;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic        last_of_run;
  } pix_out_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_NEXT, ST_QSETUP, ST_READ, ST_ACC,
    ST_SCORE, ST_MUL, ST_CMP, ST_DIV, ST_EMIT
  } state_e;
endpackage
`default_nettype wire

### rtl/kuwahara_rgb_filter.sv
// Top level of the streaming four-quadrant Kuwahara filter for RGB pixels.
//  channel | direction | handshake       | payload
//  in      | input     | valid / stall   | pix_in_t (red, green, blue)
//  out     | output    | valid / stall   | pix_out_t (filtered pixel and position)
//  cfg     | input     | valid / ready   | register index and write data
// Each input pixel is registered, then written to the store. For each result it completes,
// every quadrant of n clipped pixels takes a setup, one read and one add per pixel through
// the single read port, a score, a multiply and a compare; then three divisions and an emit.
// Reset clears the position and sets the default configuration; the line store is not cleared.
// The input stalls while an item is in work or a register write is offered.
// A stalled output holds the result and the block waits before the next one.
`default_nettype none
module kuwahara_rgb_filter
  import kwf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pix_in_t  in_data_i,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pix_out_t      out_data_o,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  `include "kuwahara_rgb_filter_assert.svh"

  localparam int unsigned Slots  = 2 * RadiusMax + 1;
  localparam int unsigned Depth  = StoreCols * Slots;
  localparam int unsigned ColW   = (StoreCols > 1) ? $clog2(StoreCols) : 1;
  localparam int unsigned SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam logic [12:0] MaxW13 = 13'(StoreCols);
  localparam logic [2:0]  MaxR3  = 3'(RadiusMax);
  localparam logic [4:0]  Slots5 = 5'(Slots);

  // Configuration registers
  logic [11:0] cfg_w_q;
  logic [15:0] cfg_h_q;
  logic [2:0]  cfg_r_q;
  logic [12:0] w_eff;
  logic [15:0] h_eff;
  logic [2:0]  r_eff;
  logic        cfg_we;

  assign w_eff = (cfg_w_q == 12'd0) ? 13'd1 :
                 ({1'b0, cfg_w_q} > MaxW13) ? MaxW13 : {1'b0, cfg_w_q};
  assign h_eff = (cfg_h_q == 16'd0) ? 16'd1 : cfg_h_q;
  assign r_eff = (cfg_r_q > MaxR3) ? MaxR3 : cfg_r_q;

  state_e state_q, state_d;
  assign cfg_ready = (state_q == ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;

  // Line store
  logic [23:0]      mem [Depth];
  logic [23:0]      rd_q;
  logic [AddrW-1:0] waddr, raddr;
  logic             mem_we, mem_re;

  // Input position and pixel
  logic [15:0] in_row_q, in_row_d;
  logic [11:0] in_col_q, in_col_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d;
  pix_in_t     px_q;
  logic [15:0] row_now_q;
  logic [SlotW-1:0] slot_now_q;

  // Output range of this input
  logic [15:0] ylo_q, yhi_q, y_q;
  logic [11:0] xlo_q, xhi_q, x_q;

  // Quadrant walk
  logic [1:0]  k_q;
  logic [15:0] r0_q, r1_q, yy_q;
  logic [11:0] c0_q, c1_q, xx_q;
  logic [SlotW-1:0] slot_q;
  logic [7:0]  n_q;
  logic [13:0] s_q [3];
  logic [21:0] sq_q [3];
  logic [33:0] v_q, best_v_q;
  logic [15:0] n2_q, best_n2_q;
  logic [49:0] lhs_q, rhs_q;
  logic [13:0] best_s_q [3];
  logic [7:0]  best_n_q;
  logic [1:0]  ch_q;
  logic [7:0]  mean_q [3];
  logic        div_start, div_busy, div_run_q;
  logic [7:0]  div_quo;
  logic [13:0] div_num;
  logic        emit_go;

  pix_out_t out_q;
  logic     out_v_q;

  // Hold the input while busy or while a register write is offered
  assign in_stall   = (state_q != ST_IDLE) || cfg_valid;
  assign out_valid  = out_v_q;
  assign out_data_o = out_q;
  assign emit_go    = (state_q == ST_EMIT) && (!out_v_q || !out_stall);

  // Quadrant bounds from the pixel y_q,x_q
  logic [15:0] top, bot;
  logic [11:0] lft, rgt;
  logic [16:0] ysum;
  logic [12:0] xsum;
  assign ysum = {1'b0, y_q} + {14'd0, r_eff};
  assign xsum = {1'b0, x_q} + {10'd0, r_eff};
  assign top  = (y_q >= {13'd0, r_eff}) ? y_q - {13'd0, r_eff} : 16'd0;
  assign bot  = (ysum < {1'b0, h_eff}) ? ysum[15:0] : h_eff - 16'd1;
  assign lft  = (x_q >= {9'd0, r_eff}) ? x_q - {9'd0, r_eff} : 12'd0;
  assign rgt  = (xsum < w_eff) ? xsum[11:0] : 12'(w_eff - 13'd1);

  // Slot of the first quadrant row: step back from the slot of the current input row
  logic [15:0] q_row, row_gap;
  logic [4:0]  slot_now5, slot_back;
  assign q_row     = k_q[1] ? y_q : top;
  assign row_gap   = row_now_q - q_row;
  assign slot_now5 = {{(5-SlotW){1'b0}}, slot_now_q};
  assign slot_back = (slot_now5 >= row_gap[4:0]) ? slot_now5 - row_gap[4:0]
                                                 : slot_now5 + Slots5 - row_gap[4:0];

  logic [4:0] slot_inc;
  logic [4:0] islot_inc;
  assign slot_inc  = {{(5-SlotW){1'b0}}, slot_q} + 5'd1;
  assign islot_inc = {{(5-SlotW){1'b0}}, in_slot_q} + 5'd1;

  assign waddr  = AddrW'({in_slot_q, ColW'(in_col_q)} );
  assign raddr  = AddrW'({slot_q, ColW'(xx_q)});
  assign mem_we = (state_q == ST_WRITE);
  assign mem_re = (state_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= px_q;
    if (mem_re) rd_q <= mem[raddr];
  end

  // Pixel channel of the registered read
  logic [7:0] chv [3];
  assign chv[0] = rd_q[23:16];
  assign chv[1] = rd_q[15:8];
  assign chv[2] = rd_q[7:0];

  // Per-channel n*q - s^2 of the finished quadrant
  logic [27:0] nq [3];
  logic [27:0] ss [3];
  logic [27:0] dv [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nq[c] = 28'(n_q) * 28'(sq_q[c]);
      ss[c] = 28'(s_q[c]) * 28'(s_q[c]);
      dv[c] = nq[c] - ss[c];
    end
  end

  // Division for the three means
  assign div_num   = best_s_q[ch_q];
  assign div_start = (state_q == ST_DIV) && !div_run_q && !div_busy;
  kwf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (best_n_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid && !cfg_we) state_d = ST_WRITE;
      ST_WRITE:  state_d = (ylo_q <= yhi_q && xlo_q <= xhi_q) ? ST_QSETUP : ST_IDLE;
      ST_QSETUP: state_d = ST_READ;
      ST_READ:   state_d = ST_ACC;
      ST_ACC:    state_d = (yy_q == r1_q && xx_q == c1_q) ? ST_SCORE : ST_READ;
      ST_SCORE:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_CMP;
      ST_CMP:    state_d = (k_q == 2'd3) ? ST_DIV : ST_QSETUP;
      ST_DIV:    if (div_run_q && !div_busy && ch_q == 2'd2) state_d = ST_EMIT;
      ST_EMIT:   if (!out_v_q || !out_stall) begin
        state_d = (y_q == yhi_q && x_q == xhi_q) ? ST_IDLE : ST_QSETUP;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Control and position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= 12'd640;
      cfg_h_q   <= 16'd480;
      cfg_r_q   <= 3'd3;
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_slot_q <= '0;
      out_v_q   <= 1'b0;
      div_run_q <= 1'b0;
    end else begin
      if (out_v_q && !out_stall) out_v_q <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  cfg_w_q <= cfg_data_i[11:0];
          CFG_HEIGHT: cfg_h_q <= cfg_data_i;
          CFG_RADIUS: cfg_r_q <= cfg_data_i[2:0];
          default: ;
        endcase
        if (cfg_index_i inside {CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS}) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          in_slot_q <= '0;
        end
      end
      if (state_q == ST_WRITE) begin
        in_row_q  <= in_row_d;
        in_col_q  <= in_col_d;
        in_slot_q <= in_slot_d;
      end
      if (state_q == ST_EMIT && (!out_v_q || !out_stall)) out_v_q <= 1'b1;
      if (div_start) div_run_q <= 1'b1;
      else if (state_q == ST_DIV && div_run_q && !div_busy) div_run_q <= 1'b0;
    end
  end

  // Advance the input position
  always_comb begin
    in_col_d  = in_col_q + 12'd1;
    in_row_d  = in_row_q;
    in_slot_d = in_slot_q;
    if ({1'b0, in_col_q} + 13'd1 >= w_eff) begin
      in_col_d  = '0;
      if (in_row_q + 16'd1 < h_eff) begin
        in_row_d  = in_row_q + 16'd1;
        in_slot_d = (islot_inc == Slots5) ? '0 : SlotW'(islot_inc);
      end else begin
        in_row_d  = '0;
        in_slot_d = '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q       <= in_data_i;
        row_now_q  <= in_row_q;
        slot_now_q <= in_slot_q;
        // Range of outputs this input completes
        if (in_row_q == h_eff - 16'd1) begin
          ylo_q <= (in_row_q >= {13'd0, r_eff}) ? in_row_q - {13'd0, r_eff} : 16'd0;
          yhi_q <= h_eff - 16'd1;
        end else if (in_row_q >= {13'd0, r_eff}) begin
          ylo_q <= in_row_q - {13'd0, r_eff};
          yhi_q <= in_row_q - {13'd0, r_eff};
        end else begin
          ylo_q <= 16'd1;
          yhi_q <= 16'd0;
        end
        if ({1'b0, in_col_q} == w_eff - 13'd1) begin
          xlo_q <= (in_col_q >= {9'd0, r_eff}) ? in_col_q - {9'd0, r_eff} : 12'd0;
          xhi_q <= 12'(w_eff - 13'd1);
        end else if (in_col_q >= {9'd0, r_eff}) begin
          xlo_q <= in_col_q - {9'd0, r_eff};
          xhi_q <= in_col_q - {9'd0, r_eff};
        end else begin
          xlo_q <= 12'd1;
          xhi_q <= 12'd0;
        end
      end
      ST_WRITE: begin
        y_q <= ylo_q;
        x_q <= xlo_q;
        k_q <= 2'd0;
      end
      ST_QSETUP: begin
        // Pick the clipped bounds of quadrant k
        r0_q <= k_q[1] ? y_q : top;
        r1_q <= k_q[1] ? bot : y_q;
        c0_q <= k_q[0] ? x_q : lft;
        c1_q <= k_q[0] ? rgt : x_q;
        yy_q <= k_q[1] ? y_q : top;
        xx_q <= k_q[0] ? x_q : lft;
        slot_q <= SlotW'(slot_back);
        n_q  <= '0;
        for (int c = 0; c < 3; c++) begin
          s_q[c]  <= '0;
          sq_q[c] <= '0;
        end
      end
      ST_READ: ;
      ST_ACC: begin
        n_q <= n_q + 8'd1;
        for (int c = 0; c < 3; c++) begin
          s_q[c]  <= s_q[c] + {6'd0, chv[c]};
          sq_q[c] <= sq_q[c] + {6'd0, 16'(chv[c]) * 16'(chv[c])};
        end
        if (xx_q == c1_q) begin
          xx_q   <= c0_q;
          yy_q   <= yy_q + 16'd1;
          slot_q <= (slot_inc == Slots5) ? '0 : SlotW'(slot_inc);
        end else begin
          xx_q <= xx_q + 12'd1;
        end
      end
      ST_SCORE: begin
        // Per-channel n*q - s^2, summed
        v_q  <= 34'(dv[0]) + 34'(dv[1]) + 34'(dv[2]);
        n2_q <= {8'd0, n_q} * {8'd0, n_q};
      end
      ST_MUL: begin
        lhs_q <= {16'd0, v_q} * {34'd0, best_n2_q};
        rhs_q <= {16'd0, best_v_q} * {34'd0, n2_q};
      end
      ST_CMP: begin
        if (k_q == 2'd0 || lhs_q < rhs_q) begin
          best_v_q  <= v_q;
          best_n2_q <= n2_q;
          best_n_q  <= n_q;
          for (int c = 0; c < 3; c++) best_s_q[c] <= s_q[c];
        end
        k_q  <= k_q + 2'd1;
        ch_q <= 2'd0;
      end
      ST_DIV: begin
        if (div_run_q && !div_busy) begin
          mean_q[ch_q] <= div_quo;
          ch_q <= ch_q + 2'd1;
        end
      end
      ST_EMIT: begin
        if (!out_v_q || !out_stall) begin
          out_q.red_out     <= mean_q[0];
          out_q.green_out   <= mean_q[1];
          out_q.blue_out    <= mean_q[2];
          out_q.out_col     <= 11'(x_q);
          out_q.out_row     <= y_q;
          out_q.last_of_run <= (y_q == yhi_q && x_q == xhi_q);
          k_q <= 2'd0;
          if (x_q == xhi_q) begin
            x_q <= xlo_q;
            y_q <= y_q + 16'd1;
          end else begin
            x_q <= x_q + 12'd1;
          end
        end
      end
      default: ;
    endcase
  end

  `KWF_ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, state_q != ST_IDLE, in_stall)
  `KWF_ASSERT_IMP(a_cfg_idle, clk_i, rst_ni, cfg_ready, state_q == ST_IDLE)
  `KWF_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, emit_go, out_valid)
endmodule
`default_nettype wire

### rtl/kwf_div.sv
// Restoring divider: unsigned 14-bit sum by 8-bit count, one quotient bit per cycle.
`default_nettype none
module kwf_div
  import kwf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [13:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic             busy_o,
  output logic [7:0]       quo_o
);
  logic [3:0]  cnt_q, cnt_d;
  logic [13:0] num_q, num_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  den_q, den_d;
  logic [9:0]  trial;
  logic [8:0]  shifted;

  // Shift one numerator bit into the remainder and try a subtract
  always_comb begin
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q[7:0], num_q[13]};
    trial   = {1'b0, shifted} - {2'b0, den_q};
    if (start_i) begin
      cnt_d = 4'd14;
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 4'd0) begin
      cnt_d = cnt_q - 4'd1;
      num_d = {num_q[12:0], ~trial[9]};
      rem_d = trial[9] ? shifted : trial[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 4'd0);
  // Quotient fits 8 bits since the mean of 8-bit values never exceeds 255
  assign quo_o  = num_q[7:0];
endmodule
`default_nettype wire

### bench/kuwahara_rgb_filter_tb.sv
// Self-checking bench for the streaming four-quadrant Kuwahara RGB filter.
`default_nettype none
module kuwahara_rgb_filter_tb;
  import kwf_pkg::*;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxRadius = 7;
  localparam int unsigned Slots     = 2 * MaxRadius + 1;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainWait = 600;
  localparam int unsigned HoldLen   = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pix_in_t     in_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pix_out_t    out_data_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  kuwahara_rgb_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the filter: line store, position and registers
  bit [23:0]   line_mem [0:Slots*MaxWidth-1];
  int unsigned pos_col, pos_row;
  int unsigned reg_width, reg_height, reg_radius;

  pix_in_t     pending_pix[$];
  pix_out_t    filtered_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req = 1'b0;

  // Filter one output position from the shadow line store
  function automatic pix_out_t filter_at(int unsigned y, int unsigned x, int unsigned w,
                                         int unsigned h, int unsigned r);
    int unsigned top, bot, lft, rgt, n;
    int unsigned r0[4], r1[4], c0[4], c1[4];
    longint unsigned s[3], q[3], v, n2, best_v, best_n2, val;
    longint unsigned pick_mean[3];
    bit [23:0] px;
    pix_out_t res;
    top = (y >= r) ? y - r : 0;
    bot = (y + r < h) ? y + r : h - 1;
    lft = (x >= r) ? x - r : 0;
    rgt = (x + r < w) ? x + r : w - 1;
    r0 = '{top, top, y, y};
    r1 = '{y, y, bot, bot};
    c0 = '{lft, x, lft, x};
    c1 = '{x, rgt, x, rgt};
    best_v = 0;
    best_n2 = 1;
    pick_mean = '{0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      n = 0;
      s = '{0, 0, 0};
      q = '{0, 0, 0};
      for (int unsigned yy = r0[k]; yy <= r1[k]; yy++) begin
        for (int unsigned xx = c0[k]; xx <= c1[k]; xx++) begin
          px = line_mem[(yy % Slots) * MaxWidth + (xx % MaxWidth)];
          for (int ch = 0; ch < 3; ch++) begin
            val = (px >> (16 - 8 * ch)) & 8'hFF;
            s[ch] += val;
            q[ch] += val * val;
          end
          n++;
        end
      end
      v = 0;
      for (int ch = 0; ch < 3; ch++) v += longint'(n) * q[ch] - s[ch] * s[ch];
      n2 = longint'(n) * n;
      if (k == 0 || v * best_n2 < best_v * n2) begin
        best_v = v;
        best_n2 = n2;
        for (int ch = 0; ch < 3; ch++) pick_mean[ch] = s[ch] / n;
      end
    end
    res.red_out     = pick_mean[0][7:0];
    res.green_out   = pick_mean[1][7:0];
    res.blue_out    = pick_mean[2][7:0];
    res.out_col     = x[10:0];
    res.out_row     = y[15:0];
    res.last_of_run = 1'b0;
    return res;
  endfunction

  // Store one accepted pixel and queue every filtered pixel it completes
  task automatic predict_pixel(pix_in_t p);
    int unsigned w, h, r, c, rw, ylo, yhi, xlo, xhi, cnt;
    pix_out_t res;
    w = (reg_width == 0) ? 1 : (reg_width > MaxWidth ? MaxWidth : reg_width);
    h = (reg_height == 0) ? 1 : reg_height;
    r = (reg_radius > MaxRadius) ? MaxRadius : reg_radius;
    c = (pos_col >= w) ? 0 : pos_col;
    rw = (pos_row >= h) ? 0 : pos_row;
    line_mem[(rw % Slots) * MaxWidth + c] = {p.red_in, p.green_in, p.blue_in};
    if (rw == h - 1) begin
      ylo = (rw >= r) ? rw - r : 0;
      yhi = h - 1;
    end else if (rw >= r) begin
      ylo = rw - r;
      yhi = ylo;
    end else begin
      ylo = 1;
      yhi = 0;
    end
    if (c == w - 1) begin
      xlo = (c >= r) ? c - r : 0;
      xhi = w - 1;
    end else if (c >= r) begin
      xlo = c - r;
      xhi = xlo;
    end else begin
      xlo = 1;
      xhi = 0;
    end
    cnt = (ylo <= yhi && xlo <= xhi) ? (yhi - ylo + 1) * (xhi - xlo + 1) : 0;
    for (int unsigned y = ylo; cnt != 0 && y <= yhi; y++) begin
      for (int unsigned x = xlo; x <= xhi; x++) begin
        res = filter_at(y, x, w, h, r);
        res.last_of_run = (y == yhi && x == xhi);
        filtered_q.push_back(res);
      end
    end
    if (c + 1 < w) begin
      pos_col = c + 1;
      pos_row = rw;
    end else begin
      pos_col = 0;
      pos_row = (rw + 1 < h) ? rw + 1 : 0;
    end
  endtask

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Pixel driver: bursts of random length separated by random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_pixel(in_data_i);
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pix.size() != 0) begin
        in_valid <= 1'b1;
        in_data_i <= pending_pix.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern, with one long hold on request
  int unsigned stretch_left = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldLen;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end else begin
        stretch_left--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: compare each filtered pixel with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      pix_out_t want;
      if (filtered_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item %p", out_data_o);
      end else begin
        want = filtered_q.pop_front();
        if (out_data_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: want %p got %p", want, out_data_o);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("kuwahara_rgb_filter_tb NOT OK");
      $finish;
    end
  end

  // Wait until every item is accepted and every result is in, then let the block settle
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_pix.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write; the shadow follows at the accepting edge
  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  reg_width = data[11:0];
      CFG_HEIGHT: reg_height = data;
      default:    reg_radius = data[2:0];
    endcase
    pos_col = 0;
    pos_row = 0;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] r);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RADIUS, r);
  endtask

  task automatic push_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_in_t p;
    p.red_in = r;
    p.green_in = g;
    p.blue_in = b;
    pending_pix.push_back(p);
  endtask

  // Random pixel: flat areas with small noise make ties, the rest is full range
  task automatic push_random(int unsigned base);
    if ($urandom_range(0, 2) == 0)
      push_rgb(8'(base + $urandom_range(0, 3)), base[7:0], 8'(base + $urandom_range(0, 1)));
    else
      push_rgb(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  // Stimulus
  initial begin
    int unsigned w, h, n, base, total;
    reg_width = 640;
    reg_height = 480;
    reg_radius = 3;
    pos_col = 0;
    pos_row = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small frame with extremes, a flat area for ties, then wrap into the next frame
    set_frame(16'd4, 16'd3, 16'd1);
    push_rgb(8'h00, 8'h00, 8'h00);
    push_rgb(8'hFF, 8'hFF, 8'hFF);
    push_rgb(8'hFF, 8'h00, 8'hFF);
    push_rgb(8'h00, 8'hFF, 8'h00);
    repeat (4) push_rgb(8'h80, 8'h80, 8'h80);
    push_rgb(8'hAA, 8'h55, 8'h01);
    push_rgb(8'h55, 8'hAA, 8'hFE);
    push_rgb(8'h80, 8'h80, 8'h80);
    push_rgb(8'h7F, 8'h81, 8'h80);
    push_rgb(8'h10, 8'h20, 8'h30);
    push_rgb(8'hF0, 8'hE0, 8'hD0);
    wait_idle();

    // Register write in the middle of a frame restarts it
    write_reg(CFG_RADIUS, 16'd0);
    push_rgb(8'hFF, 8'hFF, 8'hFF);
    push_rgb(8'h01, 8'h02, 8'h04);
    wait_idle();

    // Zero width and height act as one; width above the store is saturated
    set_frame(16'hF000, 16'd0, 16'd7);
    push_rgb(8'h12, 8'h34, 8'h56);
    push_rgb(8'hFF, 8'h00, 8'h80);
    wait_idle();
    set_frame(16'h0FFF, 16'd2, 16'd0);
    repeat (3) push_random(8'h40);
    wait_idle();
    set_frame(16'd1, 16'hFFFF, 16'd2);
    repeat (4) push_random(8'hC0);
    wait_idle();

    // Long output hold so the block backs up into its input
    set_frame(16'd6, 16'd5, 16'd1);
    hold_req = 1'b1;
    repeat (30) push_random($urandom_range(0, 255));
    wait_idle();

    // Random frames, mostly whole frames with some partial ones
    total = 0;
    while (total < 175) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(1, 5);
      set_frame(16'(w), 16'(h), 16'($urandom_range(0, 7)));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h + 3) : w * h;
      base = $urandom_range(0, 252);
      for (int unsigned i = 0; i < n; i++) push_random(base);
      total += n;
      wait_idle();
    end

    if (mismatch_cnt == 0 && filtered_q.size() == 0) begin
      $display("kuwahara_rgb_filter_tb OK");
    end else begin
      $display("kuwahara_rgb_filter_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
